@@ rtl/seg_isect_pkg.sv @@
package seg_isect_pkg;

    localparam int COORD_BITS = 16;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_CROSS    = 2'd1,
        KIND_OVERLAP  = 2'd2,
        KIND_DEGEN    = 2'd3
    } kind_t;

endpackage

@@ rtl/segment_intersection.sv @@
// channel | dir | tdata (low bit up)                        | tuser
// s_      | in  | first_ax first_ay first_bx first_by        | -
//         |     | second_ax second_ay second_bx second_by     |
// m_      | out | point_x point_y (zero filled to bytes)      | hit, contact_kind
//
// one request per cycle until the pipeline fills behind a stalled output
// the depth is set by the restoring divider, one quotient bit per stage
// reset clears the valid bits only, the pipeline needs no warm-up
// each stage holds while the next one is full and stalled, bubbles close up
// s_tready falls only when every stage is full and m_tready is low
module segment_intersection #(
    parameter int COORD_BITS = seg_isect_pkg::COORD_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // first_ax, first_ay, first_bx, first_by, second_ax, second_ay, second_bx, second_by
    input  logic [8*COORD_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // point_x, point_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // hit, contact_kind
    output logic [2:0]                m_tuser
);

    localparam int W   = COORD_BITS;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int MW  = 2 * W + 3;
    localparam int HW  = (MW + 1) / 2;
    localparam int NWP = DW + MW;
    localparam int NW  = NWP + 2;
    localparam int QB  = W + 1;
    localparam int OB  = ((2 * W + 7) / 8) * 8;
    localparam int NS  = 7 + QB;

    typedef struct packed {
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic                sgnx;
        logic                sgny;
        logic                hit;
        seg_isect_pkg::kind_t kind;
    } side_t;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // stage 0: differences and degenerate flags
    logic signed [W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy, in_dx, in_dy;
    assign in_ax = $signed(s_tdata[0*W +: W]);
    assign in_ay = $signed(s_tdata[1*W +: W]);
    assign in_bx = $signed(s_tdata[2*W +: W]);
    assign in_by = $signed(s_tdata[3*W +: W]);
    assign in_cx = $signed(s_tdata[4*W +: W]);
    assign in_cy = $signed(s_tdata[5*W +: W]);
    assign in_dx = $signed(s_tdata[6*W +: W]);
    assign in_dy = $signed(s_tdata[7*W +: W]);

    logic signed [W-1:0]  ax0_reg, ay0_reg;
    logic signed [DW-1:0] rx0_reg, ry0_reg, sx0_reg, sy0_reg;
    logic signed [DW-1:0] qx0_reg, qy0_reg, wx0_reg, wy0_reg;
    logic                 rz0_reg, sz0_reg, aeqc0_reg, box0_reg;
    logic                 box_next;

    always_comb begin
        box_next = ((in_ax >= in_cx && in_ax <= in_dx) || (in_ax >= in_dx && in_ax <= in_cx)) &&
                   ((in_ay >= in_cy && in_ay <= in_dy) || (in_ay >= in_dy && in_ay <= in_cy));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ax0_reg   <= in_ax;
            ay0_reg   <= in_ay;
            rx0_reg   <= DW'(in_bx) - DW'(in_ax);
            ry0_reg   <= DW'(in_by) - DW'(in_ay);
            sx0_reg   <= DW'(in_dx) - DW'(in_cx);
            sy0_reg   <= DW'(in_dy) - DW'(in_cy);
            qx0_reg   <= DW'(in_cx) - DW'(in_ax);
            qy0_reg   <= DW'(in_cy) - DW'(in_ay);
            wx0_reg   <= DW'(in_dx) - DW'(in_ax);
            wy0_reg   <= DW'(in_dy) - DW'(in_ay);
            rz0_reg   <= (in_ax == in_bx) && (in_ay == in_by);
            sz0_reg   <= (in_cx == in_dx) && (in_cy == in_dy);
            aeqc0_reg <= (in_ax == in_cx) && (in_ay == in_cy);
            box0_reg  <= box_next;
        end
    end

    // stage 1: products
    logic signed [PW-1:0] rs_a_reg, rs_b_reg, qs_a_reg, qs_b_reg, qr_a_reg, qr_b_reg;
    logic signed [PW-1:0] nn_a_reg, nn_b_reg, e0_a_reg, e0_b_reg, e1_a_reg, e1_b_reg;
    logic signed [W-1:0]  ax1_reg, ay1_reg;
    logic signed [DW-1:0] rx1_reg, ry1_reg;
    logic                 rz1_reg, sz1_reg, aeqc1_reg, box1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            rs_a_reg  <= PW'(rx0_reg) * PW'(sy0_reg);
            rs_b_reg  <= PW'(ry0_reg) * PW'(sx0_reg);
            qs_a_reg  <= PW'(qx0_reg) * PW'(sy0_reg);
            qs_b_reg  <= PW'(qy0_reg) * PW'(sx0_reg);
            qr_a_reg  <= PW'(qx0_reg) * PW'(ry0_reg);
            qr_b_reg  <= PW'(qy0_reg) * PW'(rx0_reg);
            nn_a_reg  <= PW'(rx0_reg) * PW'(rx0_reg);
            nn_b_reg  <= PW'(ry0_reg) * PW'(ry0_reg);
            e0_a_reg  <= PW'(qx0_reg) * PW'(rx0_reg);
            e0_b_reg  <= PW'(qy0_reg) * PW'(ry0_reg);
            e1_a_reg  <= PW'(wx0_reg) * PW'(rx0_reg);
            e1_b_reg  <= PW'(wy0_reg) * PW'(ry0_reg);
            ax1_reg   <= ax0_reg;
            ay1_reg   <= ay0_reg;
            rx1_reg   <= rx0_reg;
            ry1_reg   <= ry0_reg;
            rz1_reg   <= rz0_reg;
            sz1_reg   <= sz0_reg;
            aeqc1_reg <= aeqc0_reg;
            box1_reg  <= box0_reg;
        end
    end

    // stage 2: cross and dot products
    logic signed [SW-1:0] rxs2_reg, tn2_reg, qxr2_reg, n2_reg, e02_reg, e12_reg;
    logic signed [W-1:0]  ax2_reg, ay2_reg;
    logic signed [DW-1:0] rx2_reg, ry2_reg;
    logic                 rz2_reg, sz2_reg, aeqc2_reg, box2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            rxs2_reg  <= SW'(rs_a_reg) - SW'(rs_b_reg);
            tn2_reg   <= SW'(qs_a_reg) - SW'(qs_b_reg);
            qxr2_reg  <= SW'(qr_a_reg) - SW'(qr_b_reg);
            n2_reg    <= SW'(nn_a_reg) + SW'(nn_b_reg);
            e02_reg   <= SW'(e0_a_reg) + SW'(e0_b_reg);
            e12_reg   <= SW'(e1_a_reg) + SW'(e1_b_reg);
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            rx2_reg   <= rx1_reg;
            ry2_reg   <= ry1_reg;
            rz2_reg   <= rz1_reg;
            sz2_reg   <= sz1_reg;
            aeqc2_reg <= aeqc1_reg;
            box2_reg  <= box1_reg;
        end
    end

    // stage 3: case selection, ratio as m over d
    logic signed [SW-1:0] den, tnn, unn, c0, c1;
    logic signed [SW:0]   csum;
    logic [MW-1:0]        m_next, d_next;
    side_t                side3_next;

    always_comb begin
        den  = rxs2_reg[SW-1] ? -rxs2_reg : rxs2_reg;
        tnn  = rxs2_reg[SW-1] ? -tn2_reg : tn2_reg;
        unn  = rxs2_reg[SW-1] ? -qxr2_reg : qxr2_reg;
        c0   = (e02_reg > n2_reg) ? n2_reg : ((e02_reg < 0) ? '0 : e02_reg);
        c1   = (e12_reg > n2_reg) ? n2_reg : ((e12_reg < 0) ? '0 : e12_reg);
        csum = (SW+1)'(c0) + (SW+1)'(c1);
        side3_next.ax   = ax2_reg;
        side3_next.ay   = ay2_reg;
        side3_next.sgnx = rx2_reg[DW-1];
        side3_next.sgny = ry2_reg[DW-1];
        side3_next.hit  = 1'b0;
        side3_next.kind = seg_isect_pkg::KIND_NONE;
        m_next = '0;
        d_next = MW'(1);
        if (rxs2_reg != 0) begin
            if (tnn >= 0 && tnn <= den && unn >= 0 && unn <= den) begin
                side3_next.hit  = 1'b1;
                side3_next.kind = seg_isect_pkg::KIND_CROSS;
                m_next = MW'(tnn);
                d_next = MW'(den);
            end
        end else if (qxr2_reg == 0) begin
            if (rz2_reg) begin
                side3_next.hit  = sz2_reg ? aeqc2_reg : (box2_reg && tn2_reg == 0);
                side3_next.kind = side3_next.hit ? seg_isect_pkg::KIND_DEGEN
                                                 : seg_isect_pkg::KIND_NONE;
            end else if (!((e02_reg > n2_reg) && (e12_reg > n2_reg)) &&
                         !((e02_reg < 0) && (e12_reg < 0))) begin
                side3_next.hit  = 1'b1;
                side3_next.kind = sz2_reg ? seg_isect_pkg::KIND_DEGEN
                                          : seg_isect_pkg::KIND_OVERLAP;
                m_next = MW'(csum);
                d_next = MW'(n2_reg) << 1;
            end
        end
    end

    side_t         side3_reg;
    logic [MW-1:0] m3_reg, d3_reg;
    logic [DW-1:0] arx3_reg, ary3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            side3_reg <= side3_next;
            m3_reg    <= m_next;
            d3_reg    <= d_next;
            arx3_reg  <= rx2_reg[DW-1] ? DW'(-rx2_reg) : DW'(rx2_reg);
            ary3_reg  <= ry2_reg[DW-1] ? DW'(-ry2_reg) : DW'(ry2_reg);
        end
    end

    // stage 4: split products |r| * m
    side_t             side4_reg;
    logic [MW-1:0]     d4_reg;
    logic [DW+HW-1:0]  plx4_reg, ply4_reg;
    logic [DW+MW-HW-1:0] phx4_reg, phy4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            side4_reg <= side3_reg;
            d4_reg    <= d3_reg;
            plx4_reg  <= (DW+HW)'(arx3_reg) * (DW+HW)'(m3_reg[HW-1:0]);
            ply4_reg  <= (DW+HW)'(ary3_reg) * (DW+HW)'(m3_reg[HW-1:0]);
            phx4_reg  <= (DW+MW-HW)'(arx3_reg) * (DW+MW-HW)'(m3_reg[MW-1:HW]);
            phy4_reg  <= (DW+MW-HW)'(ary3_reg) * (DW+MW-HW)'(m3_reg[MW-1:HW]);
        end
    end

    // stage 5: rounding numerator 2n+d over 2d
    logic [NWP-1:0] nx5, ny5;
    side_t          side5_reg;
    logic [NW-1:0]  numx5_reg, numy5_reg;
    logic [MW:0]    dv5_reg;

    always_comb begin
        nx5 = NWP'(plx4_reg) + (NWP'(phx4_reg) << HW);
        ny5 = NWP'(ply4_reg) + (NWP'(phy4_reg) << HW);
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            side5_reg <= side4_reg;
            numx5_reg <= (NW'(nx5) << 1) + NW'(d4_reg);
            numy5_reg <= (NW'(ny5) << 1) + NW'(d4_reg);
            dv5_reg   <= {d4_reg, 1'b0};
        end
    end

    // divider, one quotient bit per stage, msb first
    logic [NW-1:0] remx_reg [QB];
    logic [NW-1:0] remy_reg [QB];
    logic [QB-1:0] qtx_reg  [QB];
    logic [QB-1:0] qty_reg  [QB];
    logic [MW:0]   dvd_reg  [QB];
    side_t         sided_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [NW-1:0] rx_in, ry_in, trial, rx_nx, ry_nx;
        logic [QB-1:0] qx_in, qy_in, qx_nx, qy_nx;
        logic [MW:0]   dv_in;
        side_t         sd_in;

        if (k == 0) begin : g_first
            assign rx_in = numx5_reg;
            assign ry_in = numy5_reg;
            assign qx_in = '0;
            assign qy_in = '0;
            assign dv_in = dv5_reg;
            assign sd_in = side5_reg;
        end else begin : g_next
            assign rx_in = remx_reg[k-1];
            assign ry_in = remy_reg[k-1];
            assign qx_in = qtx_reg[k-1];
            assign qy_in = qty_reg[k-1];
            assign dv_in = dvd_reg[k-1];
            assign sd_in = sided_reg[k-1];
        end

        always_comb begin
            trial = NW'(dv_in) << (QB - 1 - k);
            rx_nx = rx_in;
            ry_nx = ry_in;
            qx_nx = qx_in;
            qy_nx = qy_in;
            if (rx_in >= trial) begin
                rx_nx = rx_in - trial;
                qx_nx[QB-1-k] = 1'b1;
            end
            if (ry_in >= trial) begin
                ry_nx = ry_in - trial;
                qy_nx[QB-1-k] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[6+k]) begin
                remx_reg[k]  <= rx_nx;
                remy_reg[k]  <= ry_nx;
                qtx_reg[k]   <= qx_nx;
                qty_reg[k]   <= qy_nx;
                dvd_reg[k]   <= dv_in;
                sided_reg[k] <= sd_in;
            end
        end
    end

    // output stage: signed offset, add, saturate, zero point on a miss
    localparam logic signed [W+1:0] CMAX = ((W+2)'(1) <<< (W - 1)) - (W+2)'(1);
    localparam logic signed [W+1:0] CMIN = -((W+2)'(1) <<< (W - 1));

    side_t               sdo;
    logic signed [W+1:0] offx, offy, sumx, sumy;
    logic signed [W-1:0] px_next, py_next;

    always_comb begin
        sdo  = sided_reg[QB-1];
        offx = sdo.sgnx ? -$signed({1'b0, qtx_reg[QB-1]}) : $signed({1'b0, qtx_reg[QB-1]});
        offy = sdo.sgny ? -$signed({1'b0, qty_reg[QB-1]}) : $signed({1'b0, qty_reg[QB-1]});
        sumx = (W+2)'(sdo.ax) + offx;
        sumy = (W+2)'(sdo.ay) + offy;
        px_next = (sumx > CMAX) ? W'(CMAX) : ((sumx < CMIN) ? W'(CMIN) : W'(sumx));
        py_next = (sumy > CMAX) ? W'(CMAX) : ((sumy < CMIN) ? W'(CMIN) : W'(sumy));
        if (!sdo.hit) begin
            px_next = '0;
            py_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            m_tdata <= OB'({py_next, px_next});
            m_tuser <= {sdo.kind, sdo.hit};
        end
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata == '0 && m_tuser[2:1] == seg_isect_pkg::KIND_NONE)
        else $error("miss with nonzero payload");

    a_hit_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] != seg_isect_pkg::KIND_NONE)
        else $error("hit without contact kind");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && v_reg == '1)
        else $error("input blocked while pipeline has room");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NS-2] |-> remx_reg[QB-1] < NW'(dvd_reg[QB-1]) &&
                        remy_reg[QB-1] < NW'(dvd_reg[QB-1]))
        else $error("divider remainder out of range");
`endif

endmodule

@@ tb/sv/seg_isect_checker.sv @@
`timescale 1ns / 100ps

module seg_isect_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending_count,
    output int           result_count,
    output int           kind_seen [4]
);

    typedef struct packed {
        logic                 hit;
        seg_isect_pkg::kind_t kind;
        logic [15:0]          px;
        logic [15:0]          py;
    } contact_t;

    contact_t contact_q[$];

    function automatic longint round_ratio(longint num, longint den);
        if (num >= 0) begin
            return (2 * num + den) / (2 * den);
        end
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic logic [15:0] clamp_coord(longint v);
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    function automatic longint xprod(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic contact_t predict_contact(logic [127:0] d);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint rx, ry, sx, sy, qx, qy, rxs, qxr, tn, un, den;
        longint n, e0, e1, c0, c1, lo, hi;
        logic rzero, szero, hit;
        seg_isect_pkg::kind_t kind;
        longint px, py;
        contact_t res;
        ax = $signed(d[15:0]);    ay = $signed(d[31:16]);
        bx = $signed(d[47:32]);   by = $signed(d[63:48]);
        cx = $signed(d[79:64]);   cy = $signed(d[95:80]);
        dx = $signed(d[111:96]);  dy = $signed(d[127:112]);
        rx = bx - ax; ry = by - ay;
        sx = dx - cx; sy = dy - cy;
        qx = cx - ax; qy = cy - ay;
        rxs = xprod(rx, ry, sx, sy);
        qxr = xprod(qx, qy, rx, ry);
        hit = 0; kind = seg_isect_pkg::KIND_NONE; px = 0; py = 0;
        if (rxs != 0) begin
            tn = xprod(qx, qy, sx, sy);
            un = qxr;
            den = rxs;
            if (den < 0) begin
                den = -den; tn = -tn; un = -un;
            end
            if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
                hit = 1; kind = seg_isect_pkg::KIND_CROSS;
                px = ax + round_ratio(rx * tn, den);
                py = ay + round_ratio(ry * tn, den);
            end
        end else if (qxr == 0) begin
            rzero = (rx == 0 && ry == 0);
            szero = (sx == 0 && sy == 0);
            if (rzero) begin
                if (szero) begin
                    hit = (ax == cx && ay == cy);
                end else begin
                    hit = ax >= (cx < dx ? cx : dx) && ax <= (cx > dx ? cx : dx) &&
                          ay >= (cy < dy ? cy : dy) && ay <= (cy > dy ? cy : dy) &&
                          xprod(ax - cx, ay - cy, sx, sy) == 0;
                end
                if (hit) begin
                    kind = seg_isect_pkg::KIND_DEGEN; px = ax; py = ay;
                end
            end else begin
                n = rx * rx + ry * ry;
                e0 = qx * rx + qy * ry;
                e1 = (dx - ax) * rx + (dy - ay) * ry;
                lo = e0 < e1 ? e0 : e1;
                hi = e0 > e1 ? e0 : e1;
                if (!(lo > n) && !(hi < 0)) begin
                    c0 = e0 > n ? n : (e0 < 0 ? 0 : e0);
                    c1 = e1 > n ? n : (e1 < 0 ? 0 : e1);
                    hit = 1;
                    kind = szero ? seg_isect_pkg::KIND_DEGEN : seg_isect_pkg::KIND_OVERLAP;
                    px = ax + round_ratio(rx * (c0 + c1), 2 * n);
                    py = ay + round_ratio(ry * (c0 + c1), 2 * n);
                end
            end
        end
        res.hit = hit;
        res.kind = hit ? kind : seg_isect_pkg::KIND_NONE;
        res.px = hit ? clamp_coord(px) : 16'd0;
        res.py = hit ? clamp_coord(py) : 16'd0;
        return res;
    endfunction

    assign pending_count = contact_q.size();

    always @(posedge aclk) begin
        contact_t want, got;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
            for (int k = 0; k < 4; k++) begin
                kind_seen[k] <= 0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                contact_q.push_back(predict_contact(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.hit = m_tuser[0];
                got.kind = seg_isect_pkg::kind_t'(m_tuser[2:1]);
                got.px = m_tdata[15:0];
                got.py = m_tdata[31:16];
                result_count <= result_count + 1;
                if (contact_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = contact_q.pop_front();
                    kind_seen[want.kind] <= kind_seen[want.kind] + 1;
                    if (got !== want) begin
                        $display("%0t: mismatch, expected hit %b kind %s x %h y %h, actual hit %b kind %0d x %h y %h",
                                 $time, want.hit, want.kind.name(), want.px, want.py,
                                 got.hit, m_tuser[2:1], got.px, got.py);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;

    int fail_count, pending_count, result_count;
    int kind_seen [4];
    int idle_cycles;
    logic calm_tail = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    segment_intersection DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    seg_isect_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .kind_seen(kind_seen)
    );

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // result side stalls in bursts
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (!calm_tail && $urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 11);
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($signed($urandom_range(0, 8)) * 16'sd256 - 16'sd1024);
        endcase
    endfunction

    function automatic logic [127:0] pack_pair(logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] bx, logic [15:0] by,
                                               logic [15:0] cx, logic [15:0] cy,
                                               logic [15:0] dx, logic [15:0] dy);
        return {dy, dx, cy, cx, by, bx, ay, ax};
    endfunction

    function automatic logic [127:0] random_pair();
        logic [15:0] v [8];
        int mode, pick, k;
        logic signed [15:0] t;
        mode = $urandom_range(0, 2);
        for (k = 0; k < 8; k++) begin
            v[k] = rand_coord(mode);
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                v[2] = v[0]; v[3] = v[1];
            end
            1: begin
                v[6] = v[4]; v[7] = v[5];
            end
            2: begin
                v[2] = v[0]; v[3] = v[1]; v[4] = v[0]; v[5] = v[1];
                v[6] = v[4]; v[7] = v[5];
            end
            3, 4: begin
                // second segment on the line through the first
                t = $signed(16'($urandom_range(0, 6))) - 2;
                v[2] = 16'($signed(v[0]) + 16'sd3 * $signed(16'($urandom_range(0, 40)) - 20));
                v[3] = 16'($signed(v[1]) + 16'sd3 * $signed(16'($urandom_range(0, 40)) - 20));
                v[4] = 16'($signed(v[0]) + t * ($signed(v[2]) - $signed(v[0])));
                v[5] = 16'($signed(v[1]) + t * ($signed(v[3]) - $signed(v[1])));
                t = $signed(16'($urandom_range(0, 6))) - 2;
                v[6] = 16'($signed(v[0]) + t * ($signed(v[2]) - $signed(v[0])));
                v[7] = 16'($signed(v[1]) + t * ($signed(v[3]) - $signed(v[1])));
            end
            5: begin
                // first is a point on the second segment
                v[6] = 16'($signed(v[4]) + 16'sd2 * $signed(16'($urandom_range(0, 20)) - 10));
                v[7] = 16'($signed(v[5]) + 16'sd2 * $signed(16'($urandom_range(0, 20)) - 10));
                v[0] = 16'(($signed(v[4]) + $signed(v[6])) >>> 1);
                v[1] = 16'(($signed(v[5]) + $signed(v[7])) >>> 1);
                v[2] = v[0]; v[3] = v[1];
            end
            default: ;
        endcase
        return pack_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    task automatic send_pair(logic [127:0] d);
        s_tdata <= d;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic source_gap();
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    initial begin
        logic [127:0] directed [$];
        int waited;
        directed = '{
            pack_pair(16'h0000, 16'h0000, 16'h0400, 16'h0400, 16'h0000, 16'h0400, 16'h0400, 16'h0000),
            pack_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100),
            pack_pair(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0200, 16'h0000, 16'h0600, 16'h0000),
            pack_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0200, 16'h0000, 16'h0300, 16'h0000),
            pack_pair(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100),
            pack_pair(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0100, 16'h0200, 16'h0100),
            pack_pair(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0200, 16'h0200),
            pack_pair(16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0200, 16'h0200),
            pack_pair(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0200, 16'h0000, 16'h0200, 16'h0000),
            pack_pair(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0200, 16'h0100, 16'h0200, 16'h0100),
            pack_pair(16'h0000, 16'h0000, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0800, 16'h0000),
            pack_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000),
            pack_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000),
            pack_pair(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h7fff),
            pack_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff),
            pack_pair(16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h0001, 16'hffff, 16'h0001, 16'h0001),
            pack_pair(16'h0000, 16'h0000, 16'hfffd, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h0001),
            pack_pair(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0500, 16'h0000, 16'hff00, 16'h0000),
            pack_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
            pack_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff)
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send_pair(directed[i]);
        end
        for (int i = 0; i < 1400; i++) begin
            if (i == 1200) begin
                calm_tail = 1;
            end
            source_gap();
            send_pair(random_pair());
        end
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        waited = 0;
        while (waited < 2 * LATENCY) begin
            @(posedge aclk);
            waited++;
        end
        $display("covered %0d segment pairs: %0d none, %0d crossing, %0d overlap, %0d point",
                 result_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("with random stalls on both channels and an unstalled tail");
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
